// ===== rtl/rmap_target_memory_access_assert.svh =====
// Assertion macros shared by the RMAP target memory access block.
`ifndef RMAP_TARGET_MEMORY_ACCESS_ASSERT_SVH
`define RMAP_TARGET_MEMORY_ACCESS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMTA_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmta: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RMTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmta: next-cycle check failed");

`endif

// ===== rtl/rmta_pkg.sv =====
// ----------------------------------------------------------------------------
// rmta_pkg
// Types and constants shared by the RMAP target memory access modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rmta_pkg;

    localparam int MEM_BYTES_DEF     = 128;
    localparam int RMW_MAX_BYTES_DEF = 8;
    localparam int ADDR_MAX_W        = 16;
    localparam int QUEUE_DEPTH       = 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MATCH_KEY   = 2'd0;
    localparam logic [1:0] CFG_OWN_LA      = 2'd1;
    localparam logic [1:0] CFG_WINDOW_BASE = 2'd2;
    localparam logic [1:0] CFG_WINDOW_SIZE = 2'd3;

    localparam logic [7:0]  RST_MATCH_KEY   = 8'd0;
    localparam logic [7:0]  RST_OWN_LA      = 8'd254;
    localparam logic [39:0] RST_WINDOW_BASE = 40'd256;
    localparam logic [7:0]  RST_WINDOW_SIZE = 8'd128;

    // Item operations.
    localparam logic [2:0] OP_READ_CMD  = 3'd0;
    localparam logic [2:0] OP_WRITE_CMD = 3'd1;
    localparam logic [2:0] OP_RMW_CMD   = 3'd2;
    localparam logic [2:0] OP_DATA      = 3'd3;
    localparam logic [2:0] OP_READ_NEXT = 3'd4;

    // Result status codes.
    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_BAD_KEY     = 3'd1;
    localparam logic [2:0] STAT_BAD_LA      = 3'd2;
    localparam logic [2:0] STAT_NOT_AUTH    = 3'd3;
    localparam logic [2:0] STAT_NO_TRANSFER = 3'd4;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_RMW    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [2:0]             status;
        logic                   last;
        logic [ADDR_MAX_W-1:0]  addr;
        logic [7:0]             data;
        logic [7:0]             mask;
    } t_job;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/rmta_fifo.sv =====
// ----------------------------------------------------------------------------
// rmta_fifo
// Small synchronous queue of packed words with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rmta_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = rmta_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_din,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_dout,
    output logic              o_empty
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [PTRW-1:0] r_wr;
    logic [PTRW-1:0] r_rd;
    logic [CNTW-1:0] r_count;
    logic [PTRW-1:0] n_wr;
    logic [PTRW-1:0] n_rd;
    logic            push_ok;
    logic            pop_ok;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_dout  = r_mem[r_rd];
    assign n_wr    = (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= n_wr;
            end
            if (pop_ok) begin
                r_rd <= n_rd;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_din;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rmta_front.sv =====
// ----------------------------------------------------------------------------
// rmta_front
// Holds the configuration and the transfer state, checks commands and turns
// every accepted item into one job for the memory side.
// ----------------------------------------------------------------------------
`default_nettype none

module rmta_front #(
    parameter int MEM_BYTES     = rmta_pkg::MEM_BYTES_DEF,
    parameter int RMW_MAX_BYTES = rmta_pkg::RMW_MAX_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [39:0]  i_cfg_data,
    input  wire logic         i_accept,
    input  wire logic [2:0]   i_operation,
    input  wire logic [7:0]   i_key,
    input  wire logic [7:0]   i_logical_address,
    input  wire logic [39:0]  i_dest_addr,
    input  wire logic         i_increment,
    input  wire logic [23:0]  i_xfer_len,
    input  wire logic [7:0]   i_data_byte,
    output rmta_pkg::t_job    o_job
);

    localparam int AW  = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int SZW = $clog2(MEM_BYTES + 1);
    localparam int HW  = $clog2(RMW_MAX_BYTES + 1);
    localparam int PW  = $clog2(2 * RMW_MAX_BYTES + 1);
    localparam int BW  = (RMW_MAX_BYTES > 1) ? $clog2(RMW_MAX_BYTES) : 1;
    localparam int AMW = rmta_pkg::ADDR_MAX_W;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_RMW   = 2'd3
    } t_mode;

    logic [7:0]     r_match_key;
    logic [7:0]     r_own_la;
    logic [39:0]    r_win_base;
    logic [7:0]     r_win_size;

    logic [AW-1:0]  r_cursor;
    logic [SZW-1:0] r_left;
    t_mode          r_mode;
    logic [PW-1:0]  r_phase;
    logic [HW-1:0]  r_half;
    logic [7:0]     r_rmw_buf [RMW_MAX_BYTES];

    logic [AW-1:0]  n_cursor;
    logic [SZW-1:0] n_left;
    t_mode          n_mode;
    logic [PW-1:0]  n_phase;
    logic [HW-1:0]  n_half;

    logic [SZW-1:0] eff_size;
    logic [40:0]    diff;
    logic           start_ok;
    logic [SZW-1:0] off;
    logic [24:0]    room;
    logic           len_ok;
    logic           rmw_len_ok;
    logic [2:0]     cmd_status;
    logic [23:0]    len_half;
    logic [HW-1:0]  half;
    logic [SZW-1:0] cmd_left;
    logic           is_rmw_cmd;
    logic           last_byte;
    logic [PW-1:0]  mask_idx;
    logic           buf_we;
    logic [BW-1:0]  buf_idx;

    // Command checks: the window size is clipped to the memory size.
    always_comb begin
        if (32'(r_win_size) > MEM_BYTES) begin
            eff_size = SZW'(MEM_BYTES);
        end else begin
            eff_size = SZW'(r_win_size);
        end
        diff       = {1'b0, i_dest_addr} - {1'b0, r_win_base};
        start_ok   = !diff[40] && (diff[39:0] < 40'(eff_size));
        off        = diff[SZW-1:0];
        room       = 25'(eff_size) - 25'(off);
        len_ok     = ({1'b0, i_xfer_len} <= room);
        rmw_len_ok = (i_xfer_len <= 24'(2 * RMW_MAX_BYTES));
        is_rmw_cmd = (i_operation == rmta_pkg::OP_RMW_CMD);
        len_half   = i_xfer_len >> 1;
        half       = len_half[HW-1:0];
        if (is_rmw_cmd) begin
            cmd_left = SZW'({half, 1'b0});
        end else begin
            cmd_left = i_xfer_len[SZW-1:0];
        end

        if (i_key != r_match_key) begin
            cmd_status = rmta_pkg::STAT_BAD_KEY;
        end else if (i_logical_address != r_own_la) begin
            cmd_status = rmta_pkg::STAT_BAD_LA;
        end else if (!start_ok) begin
            cmd_status = rmta_pkg::STAT_NOT_AUTH;
        end else if (!is_rmw_cmd && !i_increment) begin
            cmd_status = rmta_pkg::STAT_NOT_AUTH;
        end else if (!len_ok) begin
            cmd_status = rmta_pkg::STAT_NOT_AUTH;
        end else if (is_rmw_cmd && !rmw_len_ok) begin
            cmd_status = rmta_pkg::STAT_NOT_AUTH;
        end else begin
            cmd_status = rmta_pkg::STAT_OK;
        end
    end

    // Item classification and transfer state update.
    always_comb begin
        n_cursor  = r_cursor;
        n_left    = r_left;
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_half    = r_half;
        buf_we    = 1'b0;
        buf_idx   = r_phase[BW-1:0];
        last_byte = (r_left == SZW'(1));
        mask_idx  = r_phase - PW'(r_half);

        o_job        = '0;
        o_job.kind   = rmta_pkg::KIND_STATUS;
        o_job.status = rmta_pkg::STAT_NO_TRANSFER;

        case (i_operation)
            rmta_pkg::OP_READ_CMD, rmta_pkg::OP_WRITE_CMD, rmta_pkg::OP_RMW_CMD: begin
                // A new command always drops whatever transfer was open.
                n_mode       = MODE_NONE;
                n_left       = '0;
                n_phase      = '0;
                o_job.status = cmd_status;
                if (cmd_status == rmta_pkg::STAT_OK) begin
                    n_cursor = off[AW-1:0];
                    n_left   = cmd_left;
                    if (is_rmw_cmd) begin
                        n_half = half;
                    end
                    if (cmd_left != '0) begin
                        if (is_rmw_cmd) begin
                            n_mode = MODE_RMW;
                        end else if (i_operation == rmta_pkg::OP_READ_CMD) begin
                            n_mode = MODE_READ;
                        end else begin
                            n_mode = MODE_WRITE;
                        end
                    end
                end
            end
            rmta_pkg::OP_DATA: begin
                if (r_mode == MODE_WRITE) begin
                    o_job.kind   = rmta_pkg::KIND_WRITE;
                    o_job.status = rmta_pkg::STAT_OK;
                    o_job.addr   = AMW'(r_cursor);
                    o_job.data   = i_data_byte;
                    o_job.last   = last_byte;
                    n_cursor     = r_cursor + 1'b1;
                    n_left       = r_left - 1'b1;
                    if (last_byte) begin
                        n_mode = MODE_NONE;
                    end
                end else if (r_mode == MODE_RMW) begin
                    o_job.status = rmta_pkg::STAT_OK;
                    n_phase      = r_phase + 1'b1;
                    n_left       = r_left - 1'b1;
                    if (r_phase < PW'(r_half)) begin
                        buf_we = 1'b1;
                    end else begin
                        // Mask phase: combine with the data byte of the same place.
                        o_job.kind = rmta_pkg::KIND_RMW;
                        o_job.addr = AMW'(r_cursor + AW'(mask_idx));
                        o_job.data = r_rmw_buf[mask_idx[BW-1:0]];
                        o_job.mask = i_data_byte;
                        o_job.last = last_byte;
                        if (last_byte) begin
                            n_mode = MODE_NONE;
                        end
                    end
                end
            end
            rmta_pkg::OP_READ_NEXT: begin
                if (r_mode == MODE_READ) begin
                    o_job.kind   = rmta_pkg::KIND_READ;
                    o_job.status = rmta_pkg::STAT_OK;
                    o_job.addr   = AMW'(r_cursor);
                    o_job.last   = last_byte;
                    n_cursor     = r_cursor + 1'b1;
                    n_left       = r_left - 1'b1;
                    if (last_byte) begin
                        n_mode = MODE_NONE;
                    end
                end
            end
            default: begin
                o_job.status = rmta_pkg::STAT_NO_TRANSFER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_key <= rmta_pkg::RST_MATCH_KEY;
            r_own_la    <= rmta_pkg::RST_OWN_LA;
            r_win_base  <= rmta_pkg::RST_WINDOW_BASE;
            r_win_size  <= rmta_pkg::RST_WINDOW_SIZE;
            r_cursor    <= '0;
            r_left      <= '0;
            r_mode      <= MODE_NONE;
            r_phase     <= '0;
            r_half      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rmta_pkg::CFG_MATCH_KEY:   r_match_key <= i_cfg_data[7:0];
                    rmta_pkg::CFG_OWN_LA:      r_own_la    <= i_cfg_data[7:0];
                    rmta_pkg::CFG_WINDOW_BASE: r_win_base  <= i_cfg_data;
                    rmta_pkg::CFG_WINDOW_SIZE: r_win_size  <= i_cfg_data[7:0];
                    default: begin
                        r_match_key <= r_match_key;
                    end
                endcase
            end
            if (i_accept) begin
                r_cursor <= n_cursor;
                r_left   <= n_left;
                r_mode   <= n_mode;
                r_phase  <= n_phase;
                r_half   <= n_half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && buf_we) begin
            r_rmw_buf[buf_idx] <= i_data_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rmta_back.sv =====
// ----------------------------------------------------------------------------
// rmta_back
// Owns the target memory: clears it after reset, then carries out jobs one
// at a time and hands one result per job to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rmap_target_memory_access_assert.svh"

module rmta_back #(
    parameter int MEM_BYTES = rmta_pkg::MEM_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rmta_pkg::t_job i_job,
    input  wire logic           i_job_empty,
    output logic                o_job_pop,
    input  wire logic           i_out_full,
    output logic                o_out_push,
    output rmta_pkg::t_result   o_result,
    output logic                o_clearing
);

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_ACCESS = 3'b100
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic [AW-1:0]  r_clr_addr;
    logic [AW-1:0]  n_clr_addr;
    rmta_pkg::t_job r_job;
    rmta_pkg::t_job n_job;
    logic [7:0]     r_mem [MEM_BYTES];
    logic [7:0]     r_rdata;

    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [7:0]     mem_wd;
    logic           mem_re;
    logic [AW-1:0]  mem_ra;

    assign o_clearing = (r_state == S_CLEAR);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_job      = r_job;
        mem_we     = 1'b0;
        mem_wa     = i_job.addr[AW-1:0];
        mem_wd     = i_job.data;
        mem_re     = 1'b0;
        mem_ra     = i_job.addr[AW-1:0];
        o_job_pop  = 1'b0;
        o_out_push = 1'b0;
        o_result   = '0;

        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_wa     = r_clr_addr;
                mem_wd     = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_job_empty) begin
                    case (i_job.kind)
                        rmta_pkg::KIND_STATUS, rmta_pkg::KIND_WRITE: begin
                            if (!i_out_full) begin
                                o_job_pop       = 1'b1;
                                o_out_push      = 1'b1;
                                o_result.status = i_job.status;
                                o_result.last   = i_job.last;
                                mem_we          = (i_job.kind == rmta_pkg::KIND_WRITE);
                            end
                        end
                        rmta_pkg::KIND_READ, rmta_pkg::KIND_RMW: begin
                            // The old byte arrives from the memory in the next cycle.
                            o_job_pop = 1'b1;
                            mem_re    = 1'b1;
                            n_job     = i_job;
                            n_state   = S_ACCESS;
                        end
                        default: begin
                            o_job_pop = 1'b0;
                        end
                    endcase
                end
            end
            S_ACCESS: begin
                mem_wa = r_job.addr[AW-1:0];
                mem_wd = (r_job.mask & r_job.data) | (~r_job.mask & r_rdata);
                if (!i_out_full) begin
                    o_out_push          = 1'b1;
                    o_result.status     = r_job.status;
                    o_result.read_byte  = r_rdata;
                    o_result.read_valid = 1'b1;
                    o_result.last       = r_job.last;
                    mem_we              = (r_job.kind == rmta_pkg::KIND_RMW);
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    `RMTA_ASSERT_HOLDS(a_no_pop_while_clearing, i_clk, i_rst_n, r_state == S_CLEAR, !o_job_pop)
    `RMTA_ASSERT_HOLDS(a_pop_only_when_waiting, i_clk, i_rst_n, o_job_pop, !i_job_empty)
    `RMTA_ASSERT_HOLDS(a_push_only_with_room, i_clk, i_rst_n, o_out_push, !i_out_full)
    `RMTA_ASSERT_HOLDS(a_access_is_read, i_clk, i_rst_n, r_state == S_ACCESS, (r_job.kind == rmta_pkg::KIND_READ || r_job.kind == rmta_pkg::KIND_RMW))
    `RMTA_ASSERT_NEXT(a_clear_ends_idle, i_clk, i_rst_n, (r_state == S_CLEAR && r_clr_addr == CLR_LAST), r_state == S_IDLE)

endmodule

`default_nettype wire

// ===== rtl/rmap_target_memory_access.sv =====
// Commands, write bytes, read-modify-write data bytes and rejected items are finished by the
// back end straight from the job queue; read bytes and read-modify-write mask bytes also
// wait for the registered memory read.
// Throughput: one item per cycle while full is low; read and mask bytes hold the back end in
// its access state, where it takes no new job. Reset is synchronous and active low; the memory
// is then cleared one byte at a time, during which full stays high.
// ----------------------------------------------------------------------------
// rmap_target_memory_access
// RMAP target over a byte memory window: a front end checks commands and
// tracks transfers, a job queue feeds the memory back end, and a result
// queue holds finished items for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module rmap_target_memory_access #(
    parameter int MEM_BYTES     = rmta_pkg::MEM_BYTES_DEF,
    parameter int RMW_MAX_BYTES = rmta_pkg::RMW_MAX_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [39:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_operation,
    input  wire logic [7:0]  i_key,
    input  wire logic [7:0]  i_logical_address,
    input  wire logic [39:0] i_dest_addr,
    input  wire logic        i_increment,
    input  wire logic [23:0] i_xfer_len,
    input  wire logic [7:0]  i_data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_status,
    output logic [7:0]       o_read_byte,
    output logic             o_read_valid,
    output logic             o_last
);

    localparam int JW = $bits(rmta_pkg::t_job);
    localparam int RW = $bits(rmta_pkg::t_result);

    rmta_pkg::t_job    front_job;
    rmta_pkg::t_job    back_job;
    rmta_pkg::t_result back_result;
    rmta_pkg::t_result out_result;
    logic [JW-1:0]     jq_dout;
    logic [RW-1:0]     rq_dout;
    logic              accept;
    logic              jq_full;
    logic              jq_empty;
    logic              jq_pop;
    logic              rq_full;
    logic              rq_push;
    logic              clearing;

    assign full   = jq_full || clearing;
    assign accept = push && !full;

    rmta_front #(
        .MEM_BYTES     (MEM_BYTES),
        .RMW_MAX_BYTES (RMW_MAX_BYTES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_accept          (accept),
        .i_operation       (i_operation),
        .i_key             (i_key),
        .i_logical_address (i_logical_address),
        .i_dest_addr       (i_dest_addr),
        .i_increment       (i_increment),
        .i_xfer_len        (i_xfer_len),
        .i_data_byte       (i_data_byte),
        .o_job             (front_job)
    );

    rmta_fifo #(
        .W     (JW),
        .DEPTH (rmta_pkg::QUEUE_DEPTH)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_din   (front_job),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_dout  (jq_dout),
        .o_empty (jq_empty)
    );

    assign back_job = rmta_pkg::t_job'(jq_dout);

    rmta_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (back_job),
        .i_job_empty (jq_empty),
        .o_job_pop   (jq_pop),
        .i_out_full  (rq_full),
        .o_out_push  (rq_push),
        .o_result    (back_result),
        .o_clearing  (clearing)
    );

    rmta_fifo #(
        .W     (RW),
        .DEPTH (rmta_pkg::QUEUE_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_din   (back_result),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_dout  (rq_dout),
        .o_empty (empty)
    );

    assign out_result   = rmta_pkg::t_result'(rq_dout);
    assign o_status     = out_result.status;
    assign o_read_byte  = out_result.read_byte;
    assign o_read_valid = out_result.read_valid;
    assign o_last       = out_result.last;

endmodule

`default_nettype wire
